[hw/rtl/gbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_pkg: shared types and constants of the gshare branch predictor
// Counter codes, total widths and the packing of the stream data words.
// ----------------------------------------------------------------------------
package gbp_pkg;

    // Two-bit saturating counter and its codes.
    typedef logic [1:0] ctr_t;
    localparam ctr_t CTR_STRONG_NOT_TAKEN = 2'd0;
    localparam ctr_t CTR_WEAK_TAKEN       = 2'd2;
    localparam ctr_t CTR_STRONG_TAKEN     = 2'd3;

    // Running totals saturate at their all-ones value.
    localparam int unsigned TOTAL_BITS = 32;
    typedef logic [TOTAL_BITS-1:0] total_t;
    localparam total_t TOTAL_MAX = '1;

    // History length register.
    localparam int unsigned HIST_LEN_BITS = 4;
    typedef logic [HIST_LEN_BITS-1:0] hist_len_t;

    // Width of the reported table index.
    localparam int unsigned OUT_INDEX_BITS = 12;

    // Input item: branch_address, taken.
    localparam int unsigned ADDR_BITS    = 32;
    localparam int unsigned S_TDATA_BITS = 40;

    // Result item: predicted_taken, mispredicted, table_index,
    // predictions_seen, mispredictions_seen.
    localparam int unsigned M_TDATA_BITS = 80;
    localparam int unsigned M_USED_BITS  = 2 + OUT_INDEX_BITS + 2 * TOTAL_BITS;

    // Depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

[hw/rtl/gbp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_front: index formation and global history
// Accepts branches, forms the counter table index and updates the history.
// ----------------------------------------------------------------------------
module gbp_front #(
    parameter int unsigned INDEX_BITS = 12
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gbp_pkg::HIST_LEN_BITS-1:0]   cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [gbp_pkg::S_TDATA_BITS-1:0]    s_tdata,
    input  wire logic                                table_ready,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output logic [INDEX_BITS:0]                      q_data
);

    localparam int unsigned SHIFT_BITS = $clog2(INDEX_BITS + 1);

    gbp_pkg::hist_len_t     hist_len_reg;
    logic [INDEX_BITS-1:0]  hist_reg;
    logic [INDEX_BITS-1:0]  hist_next;
    gbp_pkg::hist_len_t     eff_len;
    logic [INDEX_BITS-1:0]  hmask;
    logic [INDEX_BITS-1:0]  top_bit;
    logic [INDEX_BITS-1:0]  hist_m;
    logic [INDEX_BITS-1:0]  base;
    logic [INDEX_BITS-1:0]  idx;
    logic [SHIFT_BITS-1:0]  low_bits;
    logic                   taken;
    logic                   accept;

    assign cfg_ready = 1'b1;
    assign taken     = s_tdata[gbp_pkg::ADDR_BITS];
    assign base      = s_tdata[INDEX_BITS+1:2];
    assign s_tready  = table_ready && !q_full;
    assign accept    = s_tvalid && s_tready;

    // A history length above the index width is clamped to it.
    always_comb begin
        if (32'(hist_len_reg) > INDEX_BITS) begin
            eff_len = gbp_pkg::HIST_LEN_BITS'(INDEX_BITS);
        end else begin
            eff_len = hist_len_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < INDEX_BITS; i++) begin
            hmask[i]   = (i < 32'(eff_len));
            top_bit[i] = (i + 1 == 32'(eff_len));
        end
    end

    // The masked history is folded into the top eff_len bits of the index.
    assign hist_m    = hist_reg & hmask;
    assign low_bits  = SHIFT_BITS'(INDEX_BITS) - SHIFT_BITS'(eff_len);
    assign idx       = base ^ (hist_m << low_bits);
    assign hist_next = (hist_m >> 1) | (taken ? top_bit : '0);

    assign q_push = accept;
    assign q_data = {taken, idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_len_reg <= '0;
            hist_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                hist_len_reg <= cfg_data;
            end
            if (accept && (eff_len != '0)) begin
                hist_reg <= hist_next;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/gbp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_queue: short queue between front and back
// Holds classified branches so that each side can stall on its own.
// ----------------------------------------------------------------------------
module gbp_queue #(
    parameter int unsigned WIDTH = 13
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int unsigned PTR_BITS = $clog2(gbp_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0]    entry_reg [gbp_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;

    assign full     = (count_reg == (PTR_BITS+1)'(gbp_pkg::QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/gbp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_back: counter table update and result output
// Reads, steps and writes the 2-bit counters, keeps the totals and drives
// the result stream. Clears the table after reset.
// ----------------------------------------------------------------------------
module gbp_back #(
    parameter int unsigned INDEX_BITS = 12
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             q_valid,
    input  wire logic [INDEX_BITS:0]              q_data,
    output logic                                  q_pop,
    output logic                                  table_ready,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [gbp_pkg::M_TDATA_BITS-1:0]      m_tdata
);

    localparam int unsigned DEPTH = 2 ** INDEX_BITS;

    gbp_pkg::ctr_t          table_mem [DEPTH];
    logic [INDEX_BITS:0]    clear_cnt_reg;

    // Read stage: the item whose counter has just been read.
    logic                   b_valid_reg;
    logic [INDEX_BITS-1:0]  b_idx_reg;
    logic                   b_taken_reg;
    gbp_pkg::ctr_t          rdata_reg;

    // Last counter written, for a read that raced with that write.
    logic                   fwd_valid_reg;
    logic [INDEX_BITS-1:0]  fwd_idx_reg;
    gbp_pkg::ctr_t          fwd_ctr_reg;

    gbp_pkg::total_t        pred_total_reg;
    gbp_pkg::total_t        miss_total_reg;
    gbp_pkg::total_t        pred_total_next;
    gbp_pkg::total_t        miss_total_next;

    logic                   out_valid_reg;
    logic                   out_pred_reg;
    logic                   out_miss_reg;
    logic [gbp_pkg::OUT_INDEX_BITS-1:0] out_idx_reg;

    gbp_pkg::ctr_t          ctr_cur;
    gbp_pkg::ctr_t          ctr_next;
    logic                   pred;
    logic                   miss;
    logic                   advance;

    assign table_ready = clear_cnt_reg[INDEX_BITS];
    assign advance     = b_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop       = q_valid && table_ready && (!b_valid_reg || advance);

    assign ctr_cur = (fwd_valid_reg && (fwd_idx_reg == b_idx_reg)) ? fwd_ctr_reg
                                                                   : rdata_reg;
    assign pred    = ctr_cur[1];
    assign miss    = pred != b_taken_reg;

    always_comb begin
        if (b_taken_reg) begin
            ctr_next = (ctr_cur == gbp_pkg::CTR_STRONG_TAKEN) ? ctr_cur : ctr_cur + 1'b1;
        end else begin
            ctr_next = (ctr_cur == gbp_pkg::CTR_STRONG_NOT_TAKEN) ? ctr_cur
                                                                  : ctr_cur - 1'b1;
        end
    end

    assign pred_total_next = (pred_total_reg == gbp_pkg::TOTAL_MAX) ? pred_total_reg
                                                                    : pred_total_reg + 1'b1;
    assign miss_total_next = (miss && (miss_total_reg != gbp_pkg::TOTAL_MAX))
                             ? miss_total_reg + 1'b1 : miss_total_reg;

    // Counter table: one write port shared by the clearing pass and updates.
    always_ff @(posedge aclk) begin
        if (!table_ready) begin
            table_mem[clear_cnt_reg[INDEX_BITS-1:0]] <= gbp_pkg::CTR_WEAK_TAKEN;
        end else if (advance) begin
            table_mem[b_idx_reg] <= ctr_next;
        end
        if (q_pop) begin
            rdata_reg <= table_mem[q_data[INDEX_BITS-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_idx_reg   <= q_data[INDEX_BITS-1:0];
            b_taken_reg <= q_data[INDEX_BITS];
        end
        if (advance) begin
            fwd_idx_reg  <= b_idx_reg;
            fwd_ctr_reg  <= ctr_next;
            out_pred_reg <= pred;
            out_miss_reg <= miss;
            out_idx_reg  <= gbp_pkg::OUT_INDEX_BITS'(b_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg  <= '0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            pred_total_reg <= '0;
            miss_total_reg <= '0;
        end else begin
            if (!table_ready) begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (q_pop) begin
                b_valid_reg <= 1'b1;
            end else if (advance) begin
                b_valid_reg <= 1'b0;
            end
            if (advance) begin
                fwd_valid_reg  <= 1'b1;
                out_valid_reg  <= 1'b1;
                pred_total_reg <= pred_total_next;
                miss_total_reg <= miss_total_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(gbp_pkg::M_TDATA_BITS - gbp_pkg::M_USED_BITS)'(0),
                       miss_total_reg, pred_total_reg, out_idx_reg,
                       out_miss_reg, out_pred_reg};

endmodule
`default_nettype wire

[hw/rtl/gshare_branch_predictor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gshare_branch_predictor: gshare or bimodal predictor on 2-bit counters
// Predicts each resolved branch, trains its counter and keeps the totals.
// ----------------------------------------------------------------------------
// Path: an accepted item goes through the queue, read stage and output registers.
// Throughput: one item per cycle unless the result stream stalls, set by the
// single table read-modify-write port, with the last written counter forwarded
// to a racing read. Reset: history, history length and totals clear at once;
// the counter table is then swept to weakly taken, one entry per cycle, during
// which s_tready stays low. Configuration writes are taken.
// ----------------------------------------------------------------------------
module gshare_branch_predictor #(
    parameter int unsigned INDEX_BITS = 12
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration: history_bits.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gbp_pkg::HIST_LEN_BITS-1:0]   cfg_data,
    // Input item, from bit 0: branch_address[31:0], taken[32], zeros.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [gbp_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // Result item, from bit 0: predicted_taken[0], mispredicted[1],
    // table_index[13:2], predictions_seen[45:14], mispredictions_seen[77:46],
    // zeros.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [gbp_pkg::M_TDATA_BITS-1:0]         m_tdata
);

    // Each queue entry carries the table index with the outcome above it.
    localparam int unsigned Q_WIDTH = INDEX_BITS + 1;

    logic               table_ready;
    logic               q_full;
    logic               q_push;
    logic [Q_WIDTH-1:0] q_push_data;
    logic               q_pop;
    logic               q_valid;
    logic [Q_WIDTH-1:0] q_pop_data;

    // The front owns the history, so it can classify branches ahead of the
    // table update: the history depends only on the outcomes.
    gbp_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .table_ready (table_ready),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    gbp_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data)
    );

    // The back reads the counter, steps it, writes it back and registers the
    // result, so a stalled output never blocks the front directly.
    gbp_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .table_ready (table_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire
